// ----- sv/ccpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Cubic curve point evaluator package
// Widths, register indexes and types shared by the curve evaluator.
// ----------------------------------------------------------------------------
package ccpe_pkg;

   localparam int COORD_W   = 16;
   localparam int FRAC_W    = 16;
   localparam int OUT_W     = 20;
   localparam int NUM_CP    = 4;
   localparam int NUM_AXES  = 3;
   localparam int CP_W      = NUM_AXES * COORD_W;
   localparam int IDX_W     = 6;
   localparam int COUNT_W   = 7;
   localparam int DEN_W     = 6;
   localparam int CSR_IDX_W = 3;

   localparam int SAMPLES_MIN = 3;
   localparam int SAMPLES_MAX = 64;
   localparam int COUNT_RESET = 10;

   localparam int U_W    = FRAC_W + 1;
   localparam int SQ_W   = 2 * U_W;
   localparam int W_W    = 20;
   localparam int PROD_W = W_W + COORD_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int SH_W   = ACC_W - FRAC_W;

   localparam int DIV_STAGES = 4;
   localparam int DIV_BITS   = FRAC_W / DIV_STAGES;

   localparam int LATENCY = DIV_STAGES + 7;

   localparam logic [U_W-1:0] PARAM_ONE = U_W'(1) << FRAC_W;

   localparam logic [CSR_IDX_W-1:0] REG_CURVE_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CONTROL_POINT_0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CONTROL_POINT_1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CONTROL_POINT_2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CONTROL_POINT_3 = 3'd5;

   localparam logic MODE_HERMITE = 1'b0;
   localparam logic MODE_BEZIER  = 1'b1;

   typedef logic signed [OUT_W-1:0]   point_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [W_W-1:0]     weight_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic [U_W-1:0]            frac_type;

   // Four steps of restoring division with a remainder that stays below den.
   function automatic logic [DEN_W+DIV_BITS-1:0] div_step(input logic [DEN_W-1:0] rem,
                                                          input logic [DEN_W-1:0] den);
      logic [DEN_W:0]      t;
      logic [DEN_W-1:0]    r;
      logic [DIV_BITS-1:0] q;
      r = rem;
      q = '0;
      for (int k = DIV_BITS - 1; k >= 0; k--) begin
         t = {r, 1'b0};
         if (t >= {1'b0, den}) begin
            q[k] = 1'b1;
            t = t - {1'b0, den};
         end
         r = t[DEN_W-1:0];
      end
      return {r, q};
   endfunction

endpackage

// ----- sv/cubic_curve_point_eval_top.sv -----
// ----------------------------------------------------------------------------
// Cubic curve point evaluator
// Returns the Hermite or Bezier curve point for a sample index, pipelined.
// ----------------------------------------------------------------------------
// A word enters when start is high and busy is low; busy stays low, so a new
// sample index can be issued in every cycle. Each word gives one result word
// on rsp_point_x, rsp_point_y, rsp_point_z and rsp_index_out_of_range, shown
// for one cycle with rsp_valid high. The receiver cannot stall, so the
// pipeline never holds. The parameter u = i / (n - 1) comes from a divider
// whose first stage gives the integer bit and whose four further stages give
// four quotient bits each. Three multiplier stages form the powers of u and
// 1 - u, one stage the blending weights, one the twelve weighted coordinates,
// one the sums, and the output stage truncates and saturates. The curve mode,
// sample count and four control points are written on the csr_ port and read
// by the divider, weight and product stages; the user must change them only
// when no word is in flight, as the block does not enforce it. Reset clears
// the pipeline and sets Hermite mode, ten samples and zero control points.
// ----------------------------------------------------------------------------
module cubic_curve_point_eval_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ccpe_pkg::IDX_W-1:0]      req_sample_index,
   output logic                            rsp_valid,
   output ccpe_pkg::point_type             rsp_point_x,
   output ccpe_pkg::point_type             rsp_point_y,
   output ccpe_pkg::point_type             rsp_point_z,
   output logic                            rsp_index_out_of_range,
   input  logic                            csr_write_enable,
   input  logic [ccpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ccpe_pkg::CP_W-1:0]       csr_write_data
);
   import ccpe_pkg::*;

   logic                 mode_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [CP_W-1:0]      cp_ff [NUM_CP];

   logic [COUNT_W-1:0]   n_clamped;
   logic [DEN_W-1:0]     den;
   logic                 accept;

   logic                 div_valid_ff [DIV_STAGES+1];
   logic                 div_oor_ff   [DIV_STAGES+1];
   logic [DEN_W-1:0]     div_rem_ff   [DIV_STAGES+1];
   frac_type             div_quo_ff   [DIV_STAGES+1];
   logic                 div_valid_in [DIV_STAGES+1];
   logic                 div_oor_in   [DIV_STAGES+1];
   logic [DEN_W-1:0]     div_rem_in   [DIV_STAGES+1];
   frac_type             div_quo_in   [DIV_STAGES+1];
   logic [DIV_BITS-1:0]  div_q_step   [DIV_STAGES+1];

   logic                 m1_valid_ff, m1_oor_ff;
   frac_type             m1_u_ff, m1_v_ff, m1_u2_ff;
   logic [SQ_W-1:0]      m1_u2_in;

   logic                 m2_valid_ff, m2_oor_ff;
   frac_type             m2_u_ff, m2_v_ff, m2_u2_ff, m2_u3_ff, m2_v2_ff, m2_u2v_ff;
   logic [SQ_W-1:0]      m2_u3_in, m2_v2_in, m2_u2v_in;

   logic                 m3_valid_ff, m3_oor_ff;
   frac_type             m3_u_ff, m3_u2_ff, m3_u3_ff, m3_u2v_ff, m3_v3_ff, m3_uv2_ff;
   logic [SQ_W-1:0]      m3_v3_in, m3_uv2_in;

   logic                 w_valid_ff, w_oor_ff;
   weight_type           w_ff [NUM_CP];
   weight_type           w_in [NUM_CP];
   weight_type           eu, eu2, eu3, eu2v, euv2, ev3, eone;

   logic                 p_valid_ff, p_oor_ff;
   prod_type             p_ff [NUM_AXES][NUM_CP];
   prod_type             p_in [NUM_AXES][NUM_CP];

   logic                 s_valid_ff, s_oor_ff;
   acc_type              s_ff [NUM_AXES];
   acc_type              s_in [NUM_AXES];

   logic                 rsp_valid_ff, rsp_oor_ff;
   point_type            rsp_point_ff [NUM_AXES];
   point_type            rsp_point_in [NUM_AXES];
   logic [SH_W-1:0]      shifted [NUM_AXES];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_HERMITE;
         count_ff <= COUNT_W'(COUNT_RESET);
         for (int k = 0; k < NUM_CP; k++) begin
            cp_ff[k] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_CURVE_MODE:      mode_ff  <= csr_write_data[0];
            REG_SAMPLE_COUNT:    count_ff <= csr_write_data[COUNT_W-1:0];
            REG_CONTROL_POINT_0: cp_ff[0] <= csr_write_data;
            REG_CONTROL_POINT_1: cp_ff[1] <= csr_write_data;
            REG_CONTROL_POINT_2: cp_ff[2] <= csr_write_data;
            REG_CONTROL_POINT_3: cp_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (count_ff < COUNT_W'(SAMPLES_MIN)) begin
         n_clamped = COUNT_W'(SAMPLES_MIN);
      end else if (count_ff > COUNT_W'(SAMPLES_MAX)) begin
         n_clamped = COUNT_W'(SAMPLES_MAX);
      end else begin
         n_clamped = count_ff;
      end
      den = DEN_W'(n_clamped - COUNT_W'(1));
   end

   always_comb begin
      div_valid_in[0] = accept;
      div_oor_in[0]   = {1'b0, req_sample_index} >= n_clamped;
      div_q_step[0]   = '0;
      div_quo_in[0]   = '0;
      div_rem_in[0]   = '0;
      if (!div_oor_in[0]) begin
         if (req_sample_index >= den) begin
            div_quo_in[0] = frac_type'(1);
            div_rem_in[0] = req_sample_index - den;
         end else begin
            div_rem_in[0] = req_sample_index;
         end
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
         {div_rem_in[k], div_q_step[k]} = div_step(div_rem_ff[k-1], den);
         div_quo_in[k]   = {div_quo_ff[k-1][U_W-DIV_BITS-1:0], div_q_step[k]};
         div_valid_in[k] = div_valid_ff[k-1];
         div_oor_in[k]   = div_oor_ff[k-1];
      end
   end

   assign m1_u2_in  = div_quo_ff[DIV_STAGES] * div_quo_ff[DIV_STAGES];
   assign m2_u3_in  = m1_u2_ff * m1_u_ff;
   assign m2_v2_in  = m1_v_ff * m1_v_ff;
   assign m2_u2v_in = m1_u2_ff * m1_v_ff;
   assign m3_v3_in  = m2_v2_ff * m2_v_ff;
   assign m3_uv2_in = m2_u_ff * m2_v2_ff;

   always_comb begin
      eu   = signed'(W_W'(m3_u_ff));
      eu2  = signed'(W_W'(m3_u2_ff));
      eu3  = signed'(W_W'(m3_u3_ff));
      eu2v = signed'(W_W'(m3_u2v_ff));
      euv2 = signed'(W_W'(m3_uv2_ff));
      ev3  = signed'(W_W'(m3_v3_ff));
      eone = signed'(W_W'(PARAM_ONE));
      if (mode_ff == MODE_HERMITE) begin
         w_in[0] = (eu3 <<< 1) - ((eu2 <<< 1) + eu2) + eone;
         w_in[1] = ((eu2 <<< 1) + eu2) - (eu3 <<< 1);
         w_in[2] = eu3 - (eu2 <<< 1) + eu;
         w_in[3] = eu3 - eu2;
      end else begin
         w_in[0] = eu3;
         w_in[1] = (eu2v <<< 1) + eu2v;
         w_in[2] = (euv2 <<< 1) + euv2;
         w_in[3] = ev3;
      end
   end

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         for (int k = 0; k < NUM_CP; k++) begin
            p_in[a][k] = w_ff[k] * coord_type'(cp_ff[k][a*COORD_W +: COORD_W]);
         end
         s_in[a] = ACC_W'(p_ff[a][0]) + ACC_W'(p_ff[a][1])
                 + ACC_W'(p_ff[a][2]) + ACC_W'(p_ff[a][3]);
         shifted[a] = s_ff[a][ACC_W-1:FRAC_W];
         if (s_oor_ff) begin
            rsp_point_in[a] = '0;
         end else if (shifted[a][SH_W-1:OUT_W-1] == '0
                      || shifted[a][SH_W-1:OUT_W-1] == '1) begin
            rsp_point_in[a] = point_type'(shifted[a][OUT_W-1:0]);
         end else if (shifted[a][SH_W-1]) begin
            rsp_point_in[a] = {1'b1, {(OUT_W-1){1'b0}}};
         end else begin
            rsp_point_in[a] = {1'b0, {(OUT_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            div_valid_ff[k] <= 1'b0;
         end
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         m3_valid_ff  <= 1'b0;
         w_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            div_valid_ff[k] <= div_valid_in[k];
         end
         m1_valid_ff  <= div_valid_ff[DIV_STAGES];
         m2_valid_ff  <= m1_valid_ff;
         m3_valid_ff  <= m2_valid_ff;
         w_valid_ff   <= m3_valid_ff;
         p_valid_ff   <= w_valid_ff;
         s_valid_ff   <= p_valid_ff;
         rsp_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
         div_oor_ff[k] <= div_oor_in[k];
         div_rem_ff[k] <= div_rem_in[k];
         div_quo_ff[k] <= div_quo_in[k];
      end

      m1_oor_ff <= div_oor_ff[DIV_STAGES];
      m1_u_ff   <= div_quo_ff[DIV_STAGES];
      m1_v_ff   <= PARAM_ONE - div_quo_ff[DIV_STAGES];
      m1_u2_ff  <= m1_u2_in[FRAC_W+U_W-1:FRAC_W];

      m2_oor_ff <= m1_oor_ff;
      m2_u_ff   <= m1_u_ff;
      m2_v_ff   <= m1_v_ff;
      m2_u2_ff  <= m1_u2_ff;
      m2_u3_ff  <= m2_u3_in[FRAC_W+U_W-1:FRAC_W];
      m2_v2_ff  <= m2_v2_in[FRAC_W+U_W-1:FRAC_W];
      m2_u2v_ff <= m2_u2v_in[FRAC_W+U_W-1:FRAC_W];

      m3_oor_ff <= m2_oor_ff;
      m3_u_ff   <= m2_u_ff;
      m3_u2_ff  <= m2_u2_ff;
      m3_u3_ff  <= m2_u3_ff;
      m3_u2v_ff <= m2_u2v_ff;
      m3_v3_ff  <= m3_v3_in[FRAC_W+U_W-1:FRAC_W];
      m3_uv2_ff <= m3_uv2_in[FRAC_W+U_W-1:FRAC_W];

      w_oor_ff <= m3_oor_ff;
      for (int k = 0; k < NUM_CP; k++) begin
         w_ff[k] <= w_in[k];
      end

      p_oor_ff <= w_oor_ff;
      s_oor_ff <= p_oor_ff;
      rsp_oor_ff <= s_oor_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         for (int k = 0; k < NUM_CP; k++) begin
            p_ff[a][k] <= p_in[a][k];
         end
         s_ff[a]         <= s_in[a];
         rsp_point_ff[a] <= rsp_point_in[a];
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_index_out_of_range = rsp_oor_ff;
   assign rsp_point_x            = rsp_point_ff[0];
   assign rsp_point_y            = rsp_point_ff[1];
   assign rsp_point_z            = rsp_point_ff[2];

   a_result_follows_request : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY + 1))
      else $error("result word without a request word");

   a_out_of_range_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_out_of_range) |->
         (rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0))
      else $error("out of range result carries a nonzero coordinate");

   a_param_at_most_one : assert property (@(posedge clock) disable iff (reset)
      (div_valid_ff[DIV_STAGES] && !div_oor_ff[DIV_STAGES]) |->
         (div_quo_ff[DIV_STAGES] <= PARAM_ONE))
      else $error("curve parameter above one");

endmodule
